// File: hw/rtl/alcr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the arc-length Catmull-Rom sampler.
// No dependencies; used by the top level and its checker.
package alcr_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W = 16;   // Q8.8 coordinate
    localparam int DIFF_W  = 17;   // coordinate difference
    localparam int DIST_W  = 24;   // Q16.8 running distance
    localparam int FRAC_W  = 17;   // Q1.16 fraction
    localparam int SQ_W    = 34;   // sum of three squared differences
    localparam int ROOT_W  = 35;   // square root working width
    localparam int MUL_AW  = 25;
    localparam int MUL_BW  = 18;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int HORN_W  = 24;   // Horner accumulator
    localparam int STEP_W  = 5;
    localparam int ROOT_STEPS = 17;
    localparam int DIV_STEPS  = 17;
    localparam int ROOT_TOP   = 32;

    localparam logic [FRAC_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_REFRESH = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESULT,
        S_REF_LOAD0,
        S_REF_DIFF,
        S_REF_MUL,
        S_REF_ACC,
        S_REF_SQRT,
        S_REF_WRITE,
        S_Q_TOTAL,
        S_Q_LEN,
        S_Q_SEARCH,
        S_Q_DIV,
        S_Q_PTS,
        S_C_MUL,
        S_C_ADD
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [FRAC_W-1:0]         length_fraction;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [5:0]                segment_index;
        logic [FRAC_W-1:0]         local_fraction;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [6:0]                point_count;
    } out_item_t;

endpackage

// File: hw/rtl/arc_length_catmull_rom_sampler.sv
`timescale 1ns / 1ps
// Top level of the arc-length Catmull-Rom sampler: point and distance stores,
// sequencer, one shared multiplier, bit-serial square root and divider. Uses alcr_pkg.
//
// Usage
//   s_ channel: one transaction carries an operation (add point, clear store,
//   refresh running distances, query by length fraction) and its operands.
//   m_ channel: every input transaction yields exactly one result transaction
//   with a status, the stored point count and, for a query, the segment,
//   local fraction and interpolated point.
//   The block works on one transaction at a time: s_ready is high only while
//   idle, and it drops from acceptance until the result has been taken.
// Sequencing (accept to m_valid)
//   add, clear, empty refresh, empty query: go straight to the result.
//   refresh of N points: each segment runs three
//   squares through the shared multiplier and a 17-step square root.
//   query: scales the total distance by the fraction, then searches the
//   distance entries, one per cycle through the distance memory read port,
//   runs 17 divider steps (skipped for the first point or a zero-length
//   segment), reads the four neighbor points and runs nine Horner multiply-adds.
// Reset: aresetn low empties the store and idles the sequencer; stored points and
//   distances are not cleared; the user must write them before reads (unenforced).
// Stall: while m_ready is low the result holds and no new transaction is taken.
module arc_length_catmull_rom_sampler #(
    parameter int MAX_POINTS = alcr_pkg::MAX_POINTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  alcr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output alcr_pkg::out_item_t m_data
);

    localparam int CW = $clog2(MAX_POINTS + 1);   // count width
    localparam int IW = $clog2(MAX_POINTS);       // index width

    localparam int DW  = alcr_pkg::DIFF_W;
    localparam int HW  = alcr_pkg::HORN_W;
    localparam int RW  = alcr_pkg::ROOT_W;
    localparam int FW  = alcr_pkg::FRAC_W;
    localparam int DSW = alcr_pkg::DIST_W;

    // stores
    alcr_pkg::point_t  pt_mem   [MAX_POINTS];
    logic [DSW-1:0]    dist_mem [MAX_POINTS];

    alcr_pkg::point_t  pt_rd_reg;
    logic [DSW-1:0]    dist_rd_reg;
    logic [IW-1:0]     pt_raddr, dist_raddr, dist_waddr;
    logic              pt_we, dist_we;
    logic [DSW-1:0]    dist_wdata;

    // control
    alcr_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;

    // datapath registers
    logic [CW-1:0]              idx_reg, idx_next;
    logic [FW-1:0]              t_reg, t_next;
    logic [FW-1:0]              frac_reg, frac_next;
    logic [DSW-1:0]             len_reg, len_next;
    logic [DSW-1:0]             lo_reg, lo_next;
    logic [DSW-1:0]             den_reg, den_next;
    logic [DSW:0]               rem_reg, rem_next;
    logic [FW-1:0]              quo_reg, quo_next;
    logic [IW-1:0]              seg_reg, seg_next;
    alcr_pkg::point_t           prev_reg, prev_next;
    logic signed [DW-1:0]       dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [1:0]                 axis_reg, axis_next;
    logic [1:0]                 hstep_reg, hstep_next;
    logic [alcr_pkg::SQ_W-1:0]  sumsq_reg, sumsq_next;
    logic [DSW-1:0]             acc_reg, acc_next;
    logic [RW-1:0]              rval_reg, rval_next, rres_reg, rres_next, rbit_reg, rbit_next;
    logic [alcr_pkg::STEP_W-1:0] step_reg, step_next;
    alcr_pkg::point_t           pts_reg [4];
    alcr_pkg::point_t           pts_next [4];
    logic signed [HW-1:0]       s_reg, s_next;
    alcr_pkg::out_item_t        res_reg, res_next;

    // shared multiplier
    logic signed [alcr_pkg::MUL_AW-1:0] mul_a;
    logic signed [alcr_pkg::MUL_BW-1:0] mul_b;
    logic signed [alcr_pkg::PROD_W-1:0] prod_reg, prod_next;

    // combinational helpers
    logic [CW-1:0]        last_idx;
    logic [CW:0]          k0, k1, k2, k3, kseg;
    logic [CW:0]          kaddr;
    logic signed [DW-1:0] dsel;
    logic signed [15:0]   c_t0, c_p0, c_p1, c_t1;
    logic signed [HW-1:0] e0, e1, e2, e3, a2, b2, c2, d2, coef, snew, shalf;
    logic signed [15:0]   sat_val;
    logic [RW-1:0]        rsum;
    logic [DSW:0]         dsum;
    logic [DSW:0]         rdiff;
    logic                 qbit;
    logic [31:0]          seg_wide, cnt_wide;

    assign last_idx = count_reg - CW'(1);
    assign s_ready  = (state_reg == alcr_pkg::S_IDLE);
    assign m_valid  = (state_reg == alcr_pkg::S_RESULT);

    always_comb begin
        m_data             = res_reg;
        cnt_wide           = 32'(count_reg);
        m_data.point_count = cnt_wide[6:0];
    end

    // neighbor indices, clamped at both ends
    always_comb begin
        kseg = (CW+1)'(seg_reg);
        k0   = (seg_reg == '0) ? '0 : kseg - (CW+1)'(1);
        k1   = kseg;
        k2   = (kseg + (CW+1)'(1) > (CW+1)'(last_idx)) ? (CW+1)'(last_idx)
                                                     : kseg + (CW+1)'(1);
        k3   = (kseg + (CW+1)'(2) > (CW+1)'(last_idx)) ? (CW+1)'(last_idx)
                                                     : kseg + (CW+1)'(2);
        case (step_reg[1:0])
            2'd0:    kaddr = k0;
            2'd1:    kaddr = k1;
            2'd2:    kaddr = k2;
            default: kaddr = k3;
        endcase
    end

    // per-axis curve coefficients, doubled
    always_comb begin
        case (axis_reg)
            2'd0: begin
                c_t0 = pts_reg[0].x; c_p0 = pts_reg[1].x;
                c_p1 = pts_reg[2].x; c_t1 = pts_reg[3].x;
            end
            2'd1: begin
                c_t0 = pts_reg[0].y; c_p0 = pts_reg[1].y;
                c_p1 = pts_reg[2].y; c_t1 = pts_reg[3].y;
            end
            default: begin
                c_t0 = pts_reg[0].z; c_p0 = pts_reg[1].z;
                c_p1 = pts_reg[2].z; c_t1 = pts_reg[3].z;
            end
        endcase
        e0 = {{(HW-16){c_t0[15]}}, c_t0};
        e1 = {{(HW-16){c_p0[15]}}, c_p0};
        e2 = {{(HW-16){c_p1[15]}}, c_p1};
        e3 = {{(HW-16){c_t1[15]}}, c_t1};
        a2 = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
        b2 = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        c2 = e2 - e0;
        d2 = e1 <<< 1;
        case (hstep_reg)
            2'd0:    coef = b2;
            2'd1:    coef = c2;
            default: coef = d2;
        endcase
        snew  = $signed(prod_reg[HW+15:16]) + coef;
        shalf = snew >>> 1;
        if (shalf > 24'sd32767) begin
            sat_val = 16'sh7FFF;
        end else if (shalf < -24'sd32768) begin
            sat_val = -16'sh8000;
        end else begin
            sat_val = shalf[15:0];
        end
    end

    // multiplier operand select
    always_comb begin
        case (axis_reg)
            2'd0:    dsel = dx_reg;
            2'd1:    dsel = dy_reg;
            default: dsel = dz_reg;
        endcase
        case (state_reg)
            alcr_pkg::S_REF_MUL: begin
                mul_a = {{(alcr_pkg::MUL_AW-DW){dsel[DW-1]}}, dsel};
                mul_b = {dsel[DW-1], dsel};
            end
            alcr_pkg::S_Q_TOTAL: begin
                mul_a = {1'b0, dist_rd_reg};
                mul_b = {1'b0, t_reg};
            end
            alcr_pkg::S_C_MUL: begin
                mul_a = (hstep_reg == 2'd0) ? {a2[HW-1], a2} : {s_reg[HW-1], s_reg};
                mul_b = {1'b0, frac_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // square root and divider steps
    always_comb begin
        rsum  = rres_reg + rbit_reg;
        dsum  = (DSW+1)'(acc_reg) + (DSW+1)'(rres_reg[alcr_pkg::ROOT_STEPS:0]);
        qbit  = (rem_reg >= {1'b0, den_reg});
        rdiff = qbit ? rem_reg - {1'b0, den_reg} : rem_reg;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        t_next     = t_reg;
        frac_next  = frac_reg;
        len_next   = len_reg;
        lo_next    = lo_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        seg_next   = seg_reg;
        prev_next  = prev_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        axis_next  = axis_reg;
        hstep_next = hstep_reg;
        sumsq_next = sumsq_reg;
        acc_next   = acc_reg;
        rval_next  = rval_reg;
        rres_next  = rres_reg;
        rbit_next  = rbit_reg;
        step_next  = step_reg;
        pts_next   = pts_reg;
        s_next     = s_reg;
        res_next   = res_reg;
        pt_we      = 1'b0;
        dist_we    = 1'b0;
        dist_waddr = '0;
        dist_wdata = '0;
        pt_raddr   = '0;
        dist_raddr = '0;
        seg_wide   = '0;

        unique case (state_reg)
            alcr_pkg::S_IDLE: begin
                dist_raddr = last_idx[IW-1:0];
                if (s_valid) begin
                    res_next   = '0;
                    state_next = alcr_pkg::S_RESULT;
                    case (s_data.operation)
                        alcr_pkg::OP_ADD: begin
                            if (count_reg >= CW'(MAX_POINTS)) begin
                                res_next.status = alcr_pkg::STAT_FULL;
                            end else begin
                                pt_we      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        alcr_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        alcr_pkg::OP_REFRESH: begin
                            if (count_reg != '0) begin
                                // first point sits at distance zero
                                dist_we    = 1'b1;
                                idx_next   = CW'(1);
                                acc_next   = '0;
                                state_next = alcr_pkg::S_REF_LOAD0;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                res_next.status = alcr_pkg::STAT_EMPTY;
                            end else begin
                                t_next = (s_data.length_fraction > alcr_pkg::ONE_Q16)
                                         ? alcr_pkg::ONE_Q16 : s_data.length_fraction;
                                state_next = alcr_pkg::S_Q_TOTAL;
                            end
                        end
                    endcase
                end
            end

            alcr_pkg::S_RESULT: begin
                if (m_ready) begin
                    state_next = alcr_pkg::S_IDLE;
                end
            end

            alcr_pkg::S_REF_LOAD0: begin
                prev_next = pt_rd_reg;
                pt_raddr  = idx_reg[IW-1:0];
                state_next = (idx_reg >= count_reg) ? alcr_pkg::S_RESULT
                                                    : alcr_pkg::S_REF_DIFF;
            end

            alcr_pkg::S_REF_DIFF: begin
                dx_next    = DW'(pt_rd_reg.x) - DW'(prev_reg.x);
                dy_next    = DW'(pt_rd_reg.y) - DW'(prev_reg.y);
                dz_next    = DW'(pt_rd_reg.z) - DW'(prev_reg.z);
                prev_next  = pt_rd_reg;
                axis_next  = '0;
                sumsq_next = '0;
                state_next = alcr_pkg::S_REF_MUL;
            end

            alcr_pkg::S_REF_MUL: begin
                state_next = alcr_pkg::S_REF_ACC;
            end

            alcr_pkg::S_REF_ACC: begin
                sumsq_next = sumsq_reg + prod_reg[alcr_pkg::SQ_W-1:0];
                if (axis_reg == 2'd2) begin
                    rval_next  = RW'(sumsq_next);
                    rres_next  = '0;
                    rbit_next  = RW'(1) << alcr_pkg::ROOT_TOP;
                    step_next  = alcr_pkg::STEP_W'(alcr_pkg::ROOT_STEPS);
                    state_next = alcr_pkg::S_REF_SQRT;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = alcr_pkg::S_REF_MUL;
                end
            end

            alcr_pkg::S_REF_SQRT: begin
                if (rval_reg >= rsum) begin
                    rval_next = rval_reg - rsum;
                    rres_next = (rres_reg >> 1) + rbit_reg;
                end else begin
                    rres_next = rres_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                step_next = step_reg - alcr_pkg::STEP_W'(1);
                if (step_reg == alcr_pkg::STEP_W'(1)) begin
                    state_next = alcr_pkg::S_REF_WRITE;
                end
            end

            alcr_pkg::S_REF_WRITE: begin
                dist_we    = 1'b1;
                dist_waddr = idx_reg[IW-1:0];
                dist_wdata = dsum[DSW] ? alcr_pkg::DIST_MAX : dsum[DSW-1:0];
                acc_next   = dist_wdata;
                idx_next   = idx_reg + CW'(1);
                pt_raddr   = idx_next[IW-1:0];
                state_next = (idx_next >= count_reg) ? alcr_pkg::S_RESULT
                                                     : alcr_pkg::S_REF_DIFF;
            end

            alcr_pkg::S_Q_TOTAL: begin
                state_next = alcr_pkg::S_Q_LEN;
            end

            alcr_pkg::S_Q_LEN: begin
                len_next   = prod_reg[DSW+15:16];
                idx_next   = '0;
                dist_raddr = '0;
                state_next = alcr_pkg::S_Q_SEARCH;
            end

            alcr_pkg::S_Q_SEARCH: begin
                if (idx_reg < last_idx && dist_rd_reg < len_reg) begin
                    lo_next    = dist_rd_reg;
                    idx_next   = idx_reg + CW'(1);
                    dist_raddr = idx_next[IW-1:0];
                end else begin
                    frac_next = '0;
                    step_next = '0;
                    if (idx_reg == '0) begin
                        seg_next   = '0;
                        state_next = alcr_pkg::S_Q_PTS;
                    end else begin
                        seg_next = IW'(idx_reg - CW'(1));
                        if (dist_rd_reg > lo_reg && len_reg >= lo_reg) begin
                            rem_next   = {1'b0, len_reg - lo_reg};
                            den_next   = dist_rd_reg - lo_reg;
                            quo_next   = '0;
                            step_next  = alcr_pkg::STEP_W'(alcr_pkg::DIV_STEPS);
                            state_next = alcr_pkg::S_Q_DIV;
                        end else begin
                            state_next = alcr_pkg::S_Q_PTS;
                        end
                    end
                    seg_wide = 32'(seg_next);
                    res_next.segment_index  = seg_wide[5:0];
                    res_next.local_fraction = '0;
                end
            end

            alcr_pkg::S_Q_DIV: begin
                quo_next  = {quo_reg[FW-2:0], qbit};
                rem_next  = {rdiff[DSW-1:0], 1'b0};
                step_next = step_reg - alcr_pkg::STEP_W'(1);
                if (step_reg == alcr_pkg::STEP_W'(1)) begin
                    frac_next = (quo_next > alcr_pkg::ONE_Q16) ? alcr_pkg::ONE_Q16
                                                               : quo_next;
                    res_next.local_fraction = frac_next;
                    step_next  = '0;
                    state_next = alcr_pkg::S_Q_PTS;
                end
            end

            alcr_pkg::S_Q_PTS: begin
                // issue four neighbor reads, capture each in the following cycle
                pt_raddr = kaddr[IW-1:0];
                if (step_reg != '0) begin
                    pts_next[step_reg[1:0] - 2'd1] = pt_rd_reg;
                end
                step_next = step_reg + alcr_pkg::STEP_W'(1);
                if (step_reg == alcr_pkg::STEP_W'(4)) begin
                    axis_next  = '0;
                    hstep_next = '0;
                    state_next = alcr_pkg::S_C_MUL;
                end
            end

            alcr_pkg::S_C_MUL: begin
                state_next = alcr_pkg::S_C_ADD;
            end

            alcr_pkg::S_C_ADD: begin
                s_next = snew;
                if (hstep_reg == 2'd2) begin
                    case (axis_reg)
                        2'd0:    res_next.out_x = sat_val;
                        2'd1:    res_next.out_y = sat_val;
                        default: res_next.out_z = sat_val;
                    endcase
                    hstep_next = '0;
                    if (axis_reg == 2'd2) begin
                        state_next = alcr_pkg::S_RESULT;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = alcr_pkg::S_C_MUL;
                    end
                end else begin
                    hstep_next = hstep_reg + 2'd1;
                    state_next = alcr_pkg::S_C_MUL;
                end
            end

            default: begin
                state_next = alcr_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= alcr_pkg::S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        t_reg     <= t_next;
        frac_reg  <= frac_next;
        len_reg   <= len_next;
        lo_reg    <= lo_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        seg_reg   <= seg_next;
        prev_reg  <= prev_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dz_reg    <= dz_next;
        axis_reg  <= axis_next;
        hstep_reg <= hstep_next;
        sumsq_reg <= sumsq_next;
        acc_reg   <= acc_next;
        rval_reg  <= rval_next;
        rres_reg  <= rres_next;
        rbit_reg  <= rbit_next;
        step_reg  <= step_next;
        pts_reg   <= pts_next;
        s_reg     <= s_next;
        res_reg   <= res_next;
        prod_reg  <= prod_next;
    end

    // point store: written on add, one registered read port
    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[count_reg[IW-1:0]] <= '{x: s_data.pos_x, y: s_data.pos_y, z: s_data.pos_z};
        end
        pt_rd_reg <= pt_mem[pt_raddr];
    end

    // distance store: written during refresh, one registered read port
    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd_reg <= dist_mem[dist_raddr];
    end

endmodule

// File: hw/rtl/alcr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the arc-length Catmull-Rom sampler and its bind.
// Depends on alcr_pkg and on arc_length_catmull_rom_sampler.
module alcr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input alcr_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input alcr_pkg::out_item_t m_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction in flight: never ready while a result waits
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");

    // an accepted transaction closes the input until its result is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    // an empty-store query reports nothing but the status
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == alcr_pkg::STAT_EMPTY |->
            m_data.point_count == '0 && m_data.segment_index == '0 &&
            m_data.local_fraction == '0)
        else $error("empty query carries data");

    // the local fraction never passes 1.0
    a_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.local_fraction <= alcr_pkg::ONE_Q16)
        else $error("local fraction above one");

endmodule

bind arc_length_catmull_rom_sampler alcr_checker u_alcr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
